// File: rtl/core/dll_pkg.sv
// Package with the constants, codes and types of the linked list engine.
`timescale 1ns / 1ps
package dll_pkg;
  localparam int unsigned Capacity  = 64;
  localparam int unsigned IdxBits   = 6;
  localparam int unsigned LinkBits  = 7;
  localparam int unsigned ValueBits = 32;
  localparam logic [LinkBits-1:0] NullLink = LinkBits'(Capacity);

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_SEARCH     = 3'd5,
    REQ_RSVD6      = 3'd6,
    REQ_RSVD7      = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ALLOC, S_WALK, S_WALK_RD, S_LINK, S_LINK2,
    S_FIX, S_FIX2, S_POP, S_POP2, S_SEARCH, S_SEARCH_RD, S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [LinkBits-1:0] position;
    logic [31:0]         value;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [IdxBits-1:0]  found_index;
    logic [LinkBits-1:0] length;
  } rsp_t;

  // Request from the sequencer to the node store.
  typedef struct packed {
    logic                 val_we;
    logic                 nxt_we;
    logic                 prv_we;
    logic [IdxBits-1:0]   waddr;
    logic [ValueBits-1:0] wvalue;
    logic [LinkBits-1:0]  wlink;
    logic [IdxBits-1:0]   raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [LinkBits-1:0]  next;
    logic [LinkBits-1:0]  prev;
  } mem_rsp_t;
endpackage

// File: rtl/core/dll_if.sv
// Valid and ready channel interface that carries one payload beat.
`timescale 1ns / 1ps
interface dll_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/dll_store.sv
// Node store: value, next and prev memories with a registered read port.
`timescale 1ns / 1ps
module dll_store (
  input  logic               clk_i,
  input  dll_pkg::mem_cmd_t  cmd_i,
  output dll_pkg::mem_rsp_t  rsp_o
);
  import dll_pkg::*;
  logic [ValueBits-1:0] val_mem [Capacity];
  logic [LinkBits-1:0]  nxt_mem [Capacity];
  logic [LinkBits-1:0]  prv_mem [Capacity];

  always_ff @(posedge clk_i) begin
    if (cmd_i.val_we) val_mem[cmd_i.waddr] <= cmd_i.wvalue;
    if (cmd_i.nxt_we) nxt_mem[cmd_i.waddr] <= cmd_i.wlink;
    if (cmd_i.prv_we) prv_mem[cmd_i.waddr] <= cmd_i.wlink;
    rsp_o.value <= val_mem[cmd_i.raddr];
    rsp_o.next  <= nxt_mem[cmd_i.raddr];
    rsp_o.prev  <= prv_mem[cmd_i.raddr];
  end
endmodule

// File: rtl/core/dll_seq.sv
// Sequencer that walks the list and updates links, one state step at a time.
`timescale 1ns / 1ps
module dll_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  dll_if.sink               req_if,
  dll_if.source             rsp_if,
  output dll_pkg::mem_cmd_t cmd_o,
  input  dll_pkg::mem_rsp_t mem_i
);
  import dll_pkg::*;

  state_e               state_q, state_d;
  logic [2:0]           req_q;
  logic [LinkBits-1:0]  pos_q;
  logic [ValueBits-1:0] val_q;
  logic [Capacity-1:0]  free_q, free_d;
  logic [LinkBits-1:0]  head_q, head_d, tail_q, tail_d, cnt_q, cnt_d;
  logic [LinkBits-1:0]  p_q, p_d, i_q, i_d, k_q, k_d, q_q, q_d;
  logic [2:0]           st_q, st_d;
  logic [IdxBits-1:0]   fnd_q, fnd_d;
  logic                 rvalid_q, rvalid_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 rsp_free;

  assign rsp_free = !rvalid_q || rsp_if.ready;

  // One bit a cycle: the scan index i_q doubles as the free search pointer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (req_if.valid) state_d = S_DISPATCH;
      S_DISPATCH: begin
        state_d = S_DONE;
        unique case (req_e'(req_q))
          REQ_PUSH_FRONT, REQ_PUSH_BACK:
            if (cnt_q != NullLink) state_d = S_ALLOC;
          REQ_INSERT:
            if (pos_q <= cnt_q && head_q != NullLink && cnt_q != NullLink)
              state_d = (pos_q == LinkBits'(1)) ? S_ALLOC : S_WALK;
          REQ_POP_FRONT: if (head_q != NullLink) state_d = S_POP;
          REQ_POP_BACK:  if (tail_q != NullLink) state_d = S_POP;
          REQ_SEARCH:    if (head_q != NullLink) state_d = S_SEARCH;
          default: ;
        endcase
      end
      S_WALK:      state_d = S_WALK_RD;
      S_WALK_RD: begin
        if (i_q + LinkBits'(2) >= pos_q) state_d = S_ALLOC;
        else state_d = S_WALK;
      end
      S_ALLOC:     if (free_q[i_q[IdxBits-1:0]]) state_d = S_LINK;
      S_LINK:      state_d = S_LINK2;
      S_LINK2:     state_d = S_FIX;
      S_FIX:       state_d = (req_e'(req_q) == REQ_INSERT) ? S_FIX2 : S_DONE;
      S_FIX2:      state_d = S_DONE;
      S_POP:       state_d = S_POP2;
      S_POP2:      state_d = S_DONE;
      S_SEARCH:    state_d = S_SEARCH_RD;
      S_SEARCH_RD: begin
        if (mem_i.value == val_q || mem_i.next == NullLink) state_d = S_DONE;
        else state_d = S_SEARCH;
      end
      S_DONE:      if (rsp_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    free_d = free_q; head_d = head_q; tail_d = tail_q; cnt_d = cnt_q;
    p_d = p_q; i_d = i_q; k_d = k_q; q_d = q_q; st_d = st_q; fnd_d = fnd_q;
    rvalid_d = rvalid_q;
    rsp_d = rsp_q;
    cmd_o = '0;
    cmd_o.raddr = p_q[IdxBits-1:0];
    if (rvalid_q && rsp_if.ready) rvalid_d = 1'b0;
    unique case (state_q)
      S_DISPATCH: begin
        i_d = '0; p_d = head_q; fnd_d = '0;
        st_d = ST_OK;
        unique case (req_e'(req_q))
          REQ_PUSH_FRONT, REQ_PUSH_BACK: if (cnt_q == NullLink) st_d = ST_FULL;
          REQ_INSERT:
            if (pos_q > cnt_q || head_q == NullLink) st_d = ST_BAD_POS;
            else if (cnt_q == NullLink) st_d = ST_FULL;
          REQ_POP_FRONT, REQ_POP_BACK: if (head_q == NullLink) st_d = ST_EMPTY;
          REQ_SEARCH: st_d = ST_NOT_FOUND;
          default: st_d = ST_BAD_POS;
        endcase
      end
      S_WALK_RD: begin
        p_d = mem_i.next;
        i_d = i_q + LinkBits'(1);
        if (i_q + LinkBits'(2) >= pos_q) i_d = '0;
      end
      S_ALLOC: begin
        if (free_q[i_q[IdxBits-1:0]]) begin
          k_d = i_q;
          free_d[i_q[IdxBits-1:0]] = 1'b0;
          cnt_d = cnt_q + LinkBits'(1);
        end else i_d = i_q + LinkBits'(1);
      end
      S_LINK: begin
        // Write the new node's value and prev; read data holds next of p.
        cmd_o.val_we = 1'b1; cmd_o.prv_we = 1'b1;
        cmd_o.waddr = k_q[IdxBits-1:0]; cmd_o.wvalue = val_q;
        q_d = mem_i.next;
        unique case (req_e'(req_q))
          REQ_PUSH_FRONT: cmd_o.wlink = NullLink;
          REQ_PUSH_BACK:  cmd_o.wlink = tail_q;
          default:        cmd_o.wlink = p_q;
        endcase
      end
      S_LINK2: begin
        cmd_o.nxt_we = 1'b1; cmd_o.waddr = k_q[IdxBits-1:0];
        unique case (req_e'(req_q))
          REQ_PUSH_FRONT: cmd_o.wlink = head_q;
          REQ_PUSH_BACK:  cmd_o.wlink = NullLink;
          default:        cmd_o.wlink = q_q;
        endcase
      end
      S_FIX: begin
        cmd_o.wlink = k_q;
        unique case (req_e'(req_q))
          REQ_PUSH_FRONT: begin
            head_d = k_q;
            if (head_q == NullLink) tail_d = k_q;
            else begin
              cmd_o.prv_we = 1'b1; cmd_o.waddr = head_q[IdxBits-1:0];
            end
          end
          REQ_PUSH_BACK: begin
            tail_d = k_q;
            if (tail_q == NullLink) head_d = k_q;
            else begin
              cmd_o.nxt_we = 1'b1; cmd_o.waddr = tail_q[IdxBits-1:0];
            end
          end
          default: begin
            cmd_o.nxt_we = 1'b1; cmd_o.waddr = p_q[IdxBits-1:0];
            if (q_q == NullLink) tail_d = k_q;
          end
        endcase
      end
      S_FIX2: begin
        cmd_o.wlink = k_q;
        cmd_o.waddr = q_q[IdxBits-1:0];
        cmd_o.prv_we = q_q != NullLink;
      end
      S_POP: begin
        cmd_o.raddr = (req_e'(req_q) == REQ_POP_FRONT) ? head_q[IdxBits-1:0]
                                                      : tail_q[IdxBits-1:0];
        k_d = (req_e'(req_q) == REQ_POP_FRONT) ? head_q : tail_q;
      end
      S_POP2: begin
        free_d[k_q[IdxBits-1:0]] = 1'b1;
        cnt_d = cnt_q - LinkBits'(1);
        if (head_q == tail_q) begin
          head_d = NullLink; tail_d = NullLink;
        end else if (req_e'(req_q) == REQ_POP_FRONT) begin
          head_d = mem_i.next;
          cmd_o.prv_we = 1'b1; cmd_o.waddr = mem_i.next[IdxBits-1:0];
          cmd_o.wlink = NullLink;
        end else begin
          tail_d = mem_i.prev;
          cmd_o.nxt_we = 1'b1; cmd_o.waddr = mem_i.prev[IdxBits-1:0];
          cmd_o.wlink = NullLink;
        end
      end
      S_SEARCH_RD: begin
        if (mem_i.value == val_q) begin
          st_d = ST_OK; fnd_d = i_q[IdxBits-1:0];
        end
        p_d = mem_i.next; i_d = i_q + LinkBits'(1);
      end
      S_DONE: begin
        if (rsp_free) begin
          rvalid_d = 1'b1;
          rsp_d.status = st_q;
          rsp_d.found_index = fnd_q;
          rsp_d.length = cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; free_q <= '1; head_q <= NullLink; tail_q <= NullLink;
      cnt_q <= '0; rvalid_q <= 1'b0; rsp_q <= '0;
    end else begin
      state_q <= state_d; free_q <= free_d; head_q <= head_d; tail_q <= tail_d;
      cnt_q <= cnt_d; rvalid_q <= rvalid_d; rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; i_q <= i_d; k_q <= k_d; q_q <= q_d; st_q <= st_d; fnd_q <= fnd_d;
    if (req_if.valid && req_if.ready) begin
      req_q <= (req_if.data.req_type == REQ_INSERT && req_if.data.position == '0)
               ? REQ_PUSH_FRONT : req_if.data.req_type;
      pos_q <= req_if.data.position;
      val_q <= req_if.data.value;
    end
  end

  assign req_if.ready = state_q == S_IDLE;
  assign rsp_if.valid = rvalid_q;
  assign rsp_if.data  = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NullLink) else $error("count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NullLink) == (tail_q == NullLink)) else $error("head and tail disagree");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && head_q == NullLink) |-> cnt_q == '0)
    else $error("empty list with nodes");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> int'($countones(free_q)) + int'(cnt_q) == int'(Capacity))
    else $error("free mask and count disagree");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && !rsp_if.ready) |=> (rvalid_q && $stable(rsp_q)))
    else $error("result beat changed while waiting");
endmodule

// File: rtl/core/doubly_linked_list_engine.sv
// Top level of the doubly linked list engine.
`timescale 1ns / 1ps
// Channel  Direction  Beat
// req_if   in         req_type, position, value
// rsp_if   out        status, found_index, length
// A rejected request goes straight to its result; a push scans the used slots
// below the first free one, a search reads each node that it visits, and an
// insert also walks over position-1 nodes; an insert deep into a nearly full
// pool is the slowest case.
// Reset marks every slot free and clears head, tail and count at once; no clearing pass.
// A result waits in an output register; only a second result stalls the sequencer.
module doubly_linked_list_engine (
  input logic clk_i,
  input logic rst_ni,
  dll_if.sink   req_if,
  dll_if.source rsp_if
);
  import dll_pkg::*;
  mem_cmd_t cmd;
  mem_rsp_t mrsp;
  dll_seq u_seq (.clk_i, .rst_ni, .req_if, .rsp_if, .cmd_o(cmd), .mem_i(mrsp));
  dll_store u_store (.clk_i, .cmd_i(cmd), .rsp_o(mrsp));
endmodule
